### rtl/gsbc_pkg.sv
package gsbc_pkg;

	// field widths
	localparam int ADC_W  = 12;
	localparam int LOAD_W = 16;
	localparam int IDX_W  = 6;
	localparam int TOL_W  = 10;
	localparam int RS_W   = 28;
	localparam int SUM_W  = 35;
	localparam int CFG_W  = 16;
	localparam int CIDX_W = 2;

	// divider operand widths
	localparam int DIV_W = SUM_W;
	localparam int DEN_W = ADC_W;
	localparam int CNT_W = $clog2(DIV_W + 1);

	// sample count width, one more bit so that a full wrap reads as 2**IDX_W
	localparam int N_W = IDX_W + 1;

	// converter full scale
	localparam logic [ADC_W-1:0] ADC_FULL_SCALE = ADC_W'(4095);

	// saturation value of a resistance
	localparam logic [RS_W-1:0] R_MAX = {RS_W{1'b1}};

	// register indexes
	localparam logic [CIDX_W-1:0] REG_LOAD   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MAXRD  = 2'd1;
	localparam logic [CIDX_W-1:0] REG_STABLE = 2'd2;
	localparam logic [CIDX_W-1:0] REG_TOL    = 2'd3;

	// register reset values
	localparam logic [LOAD_W-1:0] LOAD_RST   = LOAD_W'(10000);
	localparam logic [IDX_W-1:0]  MAXRD_RST  = IDX_W'(30);
	localparam logic [IDX_W-1:0]  STABLE_RST = IDX_W'(5);
	localparam logic [TOL_W-1:0]  TOL_RST    = TOL_W'(50);

	// input command codes
	localparam logic CMD_SAMPLE  = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic cap;
		logic mul;
		logic restart;
		logic div_start;
		logic div_sel_avg;
		logic latch_rs;
		logic tol;
		logic upd;
		logic latch_base;
		logic out_load;
	} ctrl_t;

	// datapath to controller status
	typedef struct packed {
		logic finish;
		logic div_done;
	} status_t;

endpackage

### rtl/gsbc_in_if.sv
interface gsbc_in_if import gsbc_pkg::*;;
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [ADC_W-1:0] adc_sample;

	modport source (output valid, output cmd, output adc_sample, input ready);
	modport sink (input valid, input cmd, input adc_sample, output ready);
endinterface

### rtl/gsbc_out_if.sv
interface gsbc_out_if import gsbc_pkg::*;;
	logic             valid;
	logic             ready;
	logic             calibrating;
	logic             finished_now;
	logic [RS_W-1:0]  sample_resistance;
	logic [IDX_W-1:0] stable_run;
	logic [RS_W-1:0]  baseline;

	modport source (output valid, output calibrating, output finished_now,
		output sample_resistance, output stable_run, output baseline, input ready);
	modport sink (input valid, input calibrating, input finished_now,
		input sample_resistance, input stable_run, input baseline, output ready);
endinterface

### rtl/gsbc_div.sv
module gsbc_div import gsbc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic [DIV_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;

	// one restoring step per cycle
	assign rem_sh  = {rem_q[DEN_W-1:0], quo_q[DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, den_q};
	assign ge      = (rem_sh >= {1'b0, den_q});

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1)) && !start;
			if (start) begin
				cnt_q <= CNT_W'(DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// quotient and remainder shift
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub : rem_sh;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### rtl/gsbc_dp.sv
module gsbc_dp import gsbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctl,
	output status_t           sts,
	input  logic [ADC_W-1:0]  adc_sample,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata,
	output logic              calibrating,
	output logic              finished_now,
	output logic [RS_W-1:0]   sample_resistance,
	output logic [IDX_W-1:0]  stable_run,
	output logic [RS_W-1:0]   baseline
);

	// configuration
	logic [LOAD_W-1:0] load_q;
	logic [IDX_W-1:0]  maxrd_q;
	logic [IDX_W-1:0]  stable_q;
	logic [TOL_W-1:0]  tol_q;

	// calibration state
	logic              busy_q;
	logic              done_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  run_q;
	logic [RS_W-1:0]   prev_q;
	logic [SUM_W-1:0]  sum_q;
	logic [RS_W-1:0]   base_q;

	// per item working registers
	logic [ADC_W-1:0]       adc_q;
	logic [RS_W-1:0]        prod_q;
	logic [DEN_W-1:0]       den_q;
	logic [RS_W-1:0]        rs_q;
	logic [TOL_W+RS_W-1:0]  tprod_q;

	// result register
	logic              res_cal_q;
	logic              res_fin_q;
	logic [RS_W-1:0]   res_rs_q;
	logic [IDX_W-1:0]  res_run_q;
	logic [RS_W-1:0]   res_base_q;

	logic [ADC_W-1:0]  adc_eff;
	logic [ADC_W-1:0]  diff;
	logic [RS_W-1:0]   delta;
	logic              stable;
	logic [IDX_W-1:0]  run_next;
	logic [IDX_W-1:0]  idx_next;
	logic              done_cond;
	logic [N_W-1:0]    n_cnt;
	logic [DIV_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [RS_W-1:0]   quo_sat;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_q   <= LOAD_RST;
			maxrd_q  <= MAXRD_RST;
			stable_q <= STABLE_RST;
			tol_q    <= TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOAD:   load_q   <= cfg_wdata[LOAD_W-1:0];
				REG_MAXRD:  maxrd_q  <= cfg_wdata[IDX_W-1:0];
				REG_STABLE: stable_q <= cfg_wdata[IDX_W-1:0];
				REG_TOL:    tol_q    <= cfg_wdata[TOL_W-1:0];
			endcase
		end
	end

	// clamp zero reading, floor difference at zero
	assign adc_eff = (adc_q == '0) ? ADC_W'(1) : adc_q;
	assign diff    = (ADC_FULL_SCALE > adc_eff) ? (ADC_FULL_SCALE - adc_eff) : '0;

	// stability check against previous resistance
	assign delta  = (rs_q > prev_q) ? (rs_q - prev_q) : (prev_q - rs_q);
	assign stable = (tprod_q < (TOL_W+RS_W)'(prev_q));

	// next counters and end of calibration
	always_comb begin
		run_next = run_q;
		if (idx_q != '0) begin
			run_next = stable ? (run_q + IDX_W'(1)) : '0;
		end
		idx_next  = idx_q + IDX_W'(1);
		done_cond = (run_next >= stable_q) || (idx_next >= maxrd_q) || (idx_next == '0);
	end

	// samples taken, a wrapped index means a full count
	assign n_cnt = (idx_q == '0) ? N_W'(1 << IDX_W) : {1'b0, idx_q};

	// divider operand select
	assign div_num = ctl.div_sel_avg ? sum_q : DIV_W'(prod_q);
	assign div_den = ctl.div_sel_avg ? DEN_W'(n_cnt) : den_q;

	gsbc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign quo_sat = (div_quo[DIV_W-1:RS_W] != '0) ? R_MAX : div_quo[RS_W-1:0];

	// calibration state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			idx_q  <= '0;
			run_q  <= '0;
			prev_q <= '0;
			sum_q  <= '0;
			base_q <= '0;
		end else begin
			if (ctl.cap) begin
				done_q <= 1'b0;
			end
			if (ctl.restart) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				run_q  <= '0;
				prev_q <= '0;
				sum_q  <= '0;
			end
			if (ctl.upd && busy_q) begin
				run_q  <= run_next;
				idx_q  <= idx_next;
				prev_q <= rs_q;
				sum_q  <= sum_q + SUM_W'(rs_q);
				if (done_cond) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
			if (ctl.latch_base) begin
				base_q <= quo_sat;
			end
		end
	end

	// per item working registers
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			adc_q <= adc_sample;
		end
		if (ctl.mul) begin
			prod_q <= RS_W'(load_q) * RS_W'(diff);
			den_q  <= adc_eff;
		end
		if (ctl.restart) begin
			rs_q <= '0;
		end else if (ctl.latch_rs) begin
			rs_q <= quo_sat;
		end
		if (ctl.tol) begin
			tprod_q <= tol_q * delta;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_cal_q  <= busy_q;
			res_fin_q  <= done_q;
			res_rs_q   <= rs_q;
			res_run_q  <= run_q;
			res_base_q <= base_q;
		end
	end

	assign sts.finish   = busy_q && done_cond;
	assign sts.div_done = div_done;

	assign calibrating       = res_cal_q;
	assign finished_now      = res_fin_q;
	assign sample_resistance = res_rs_q;
	assign stable_run        = res_run_q;
	assign baseline          = res_base_q;

endmodule

### rtl/gsbc_ctrl.sv
module gsbc_ctrl import gsbc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_cmd,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output ctrl_t   ctl,
	input  status_t sts
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MUL    = 4'd1;
	localparam logic [3:0] S_RST    = 4'd2;
	localparam logic [3:0] S_DSTART = 4'd3;
	localparam logic [3:0] S_DWAIT  = 4'd4;
	localparam logic [3:0] S_TOL    = 4'd5;
	localparam logic [3:0] S_UPD    = 4'd6;
	localparam logic [3:0] S_ASTART = 4'd7;
	localparam logic [3:0] S_AWAIT  = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_nxt;
	logic       out_valid_q;
	logic       accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// command decode
	always_comb begin
		ctl             = '0;
		ctl.cap         = accept;
		ctl.mul         = (state_q == S_MUL);
		ctl.restart     = (state_q == S_RST);
		ctl.div_start   = (state_q == S_DSTART) || (state_q == S_ASTART);
		ctl.div_sel_avg = (state_q == S_ASTART);
		ctl.latch_rs    = (state_q == S_DWAIT) && sts.div_done;
		ctl.tol         = (state_q == S_TOL);
		ctl.upd         = (state_q == S_UPD);
		ctl.latch_base  = (state_q == S_AWAIT) && sts.div_done;
		ctl.out_load    = (state_q == S_OUT) && (!out_valid_q || out_ready);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_nxt = (in_cmd == CMD_RESTART) ? S_RST : S_MUL;
				end
			end
			S_MUL:    state_nxt = S_DSTART;
			S_RST:    state_nxt = S_OUT;
			S_DSTART: state_nxt = S_DWAIT;
			S_DWAIT: begin
				if (sts.div_done) begin
					state_nxt = S_TOL;
				end
			end
			S_TOL:    state_nxt = S_UPD;
			S_UPD:    state_nxt = sts.finish ? S_ASTART : S_OUT;
			S_ASTART: state_nxt = S_AWAIT;
			S_AWAIT: begin
				if (sts.div_done) begin
					state_nxt = S_OUT;
				end
			end
			S_OUT: begin
				if (ctl.out_load) begin
					state_nxt = S_IDLE;
				end
			end
			default:  state_nxt = S_IDLE;
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// restart request goes straight to the clearing step
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_cmd == CMD_RESTART) |=> state_q == S_RST)
		else $error("restart request did not clear state");

	// divider completion only seen while waiting on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == S_DWAIT) || (state_q == S_AWAIT))
		else $error("divider done outside a wait state");

	// end of calibration always runs the averaging division
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) && sts.finish |=> state_q == S_ASTART)
		else $error("finished calibration skipped baseline division");

	// no new request while a result is pending in the datapath
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("request accepted while busy");

endmodule

### rtl/gas_sensor_baseline_calibrator_top.sv
// Gas sensor baseline calibrator. Each request is either an ADC sample or a
// restart; every request gives exactly one result. A sample's result is built
// in steps after acceptance: one multiply of load resistance by the divider
// difference, then a 35-step restoring divider that produces the sensor
// resistance, a stability multiply and the state update. The sample that ends
// calibration runs the same divider again for the baseline average. A restart
// clears the calibration state. One request is worked on at a time; the
// result sits in an output register, and the next request is taken once that
// register has been loaded. Registers are written through
// cfg_we/cfg_index/cfg_wdata by the user only while no request is in flight;
// the block itself does not enforce it.
module gas_sensor_baseline_calibrator_top import gsbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	gsbc_in_if.sink           sample,
	gsbc_out_if.source        result,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_wdata
);

	ctrl_t   ctl;
	status_t sts;

	// sequencer
	gsbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_cmd    (sample.cmd),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// arithmetic and calibration state
	gsbc_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.adc_sample        (sample.adc_sample),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.calibrating       (result.calibrating),
		.finished_now      (result.finished_now),
		.sample_resistance (result.sample_resistance),
		.stable_run        (result.stable_run),
		.baseline          (result.baseline)
	);

endmodule
